@@ hdl/state_space_plant_step_core_macros.svh @@
// ----------------------------------------------------------------------------
// State-space plant step core: assertion macros
// Shared concurrent assertion forms used by the plant step core.
// ----------------------------------------------------------------------------
`ifndef STATE_SPACE_PLANT_STEP_CORE_MACROS_SVH
`define STATE_SPACE_PLANT_STEP_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define SSPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("plant step core: same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define SSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("plant step core: next-cycle check failed");

`endif

@@ hdl/ssps_pkg.sv @@
// ----------------------------------------------------------------------------
// State-space plant step package
// Coefficient tables, coefficient quantisation and the microcode program of
// the plant step core.
// ----------------------------------------------------------------------------
package ssps_pkg;

    // Default configuration.
    localparam int STATE_COUNT_DEF    = 6;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Size of the stored coefficient tables; entries outside read as zero.
    localparam int TABLE_DIM = 6;
    localparam int TAB_IDX_W = 3;

    // Data word width for state, input and output (Q16.16).
    localparam int DATA_W = 32;

    // Coefficients in units of 1e-4: system matrix and input column.
    localparam int A_TENK [TABLE_DIM][TABLE_DIM] = '{
        '{  9652,  -172,    57,   -58,    52,  -251 },
        '{  7732,  1252,  2315,   700,  1282,  7754 },
        '{  8278, -7522,  -956,  3299, -4855,  3915 },
        '{  9948,  2655, -3848,  4212,  3927,  2899 },
        '{  7648, -4165, -4855, -3366,  -986,  7281 },
        '{ 11056,  7587, -1179,   748, -2192,  1491 }
    };
    localparam int B_TENK [TABLE_DIM] = '{ 471, 377, 4040, 485, 373, 539 };

    // Table entry by row and column; the column after the matrix is the input column.
    function automatic int tenk_coef(input int row, input int col);
        int v;
        v = 0;
        if (col == TABLE_DIM) begin
            v = B_TENK[row];
        end else begin
            v = A_TENK[row][col];
        end
        return v;
    endfunction

    // Quantise a 1e-4 value to frac fraction bits, rounding halves away from zero.
    function automatic longint coef_q(input int tenk, input int frac);
        longint mag;
        longint q;
        mag = (tenk < 0) ? -longint'(tenk) : longint'(tenk);
        q   = (mag * (64'sd1 <<< frac) + 64'sd5000) / 64'sd10000;
        return (tenk < 0) ? -q : q;
    endfunction

    // Micro-operations of the datapath.
    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_NOP,
        UOP_MAC,
        UOP_ROUND,
        UOP_ZERO,
        UOP_COMMIT
    } t_uop;

    // Jump conditions; a true condition loads the target, else the step counter advances.
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_START,
        COND_CLEAR,
        COND_COL_MORE,
        COND_ROW_MORE,
        COND_OUT_BUSY
    } t_cond;

    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    // Program addresses.
    localparam t_pc PC_WAIT   = 3'd0;
    localparam t_pc PC_DECODE = 3'd1;
    localparam t_pc PC_MAC    = 3'd2;
    localparam t_pc PC_DRAIN  = 3'd3;
    localparam t_pc PC_ROUND  = 3'd4;
    localparam t_pc PC_HOLD   = 3'd5;
    localparam t_pc PC_COMMIT = 3'd6;
    localparam t_pc PC_ZERO   = 3'd7;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Microcode program store.
    function automatic t_uword uc_rom(input t_pc pc);
        t_uword w;
        w = '{op: UOP_NOP, cond: COND_ALWAYS, target: PC_WAIT};
        unique case (pc)
            PC_WAIT:   w = '{op: UOP_WAIT,   cond: COND_NO_START, target: PC_WAIT};
            PC_DECODE: w = '{op: UOP_NOP,    cond: COND_CLEAR,    target: PC_ZERO};
            PC_MAC:    w = '{op: UOP_MAC,    cond: COND_COL_MORE, target: PC_MAC};
            PC_DRAIN:  w = '{op: UOP_NOP,    cond: COND_NONE,     target: PC_WAIT};
            PC_ROUND:  w = '{op: UOP_ROUND,  cond: COND_ROW_MORE, target: PC_MAC};
            PC_HOLD:   w = '{op: UOP_NOP,    cond: COND_OUT_BUSY, target: PC_HOLD};
            PC_COMMIT: w = '{op: UOP_COMMIT, cond: COND_ALWAYS,   target: PC_WAIT};
            PC_ZERO:   w = '{op: UOP_ZERO,   cond: COND_ALWAYS,   target: PC_HOLD};
            default:   w = '{op: UOP_NOP,    cond: COND_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

@@ hdl/state_space_plant_step_core.sv @@
// ----------------------------------------------------------------------------
// State-space plant step core
// Discrete LTI plant: each input item advances x = Ad*x + Bd*u, or zeroes x
// when clear_state is set, and yields the new last state element, using one
// shared multiply-accumulate under a microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: sample_in (32, signed); tuser: clear_state (1)
//  m_axis    out        tdata: sample_out (32, signed)
//
//  A result is computed row by row, with N = STATE_COUNT: the shared
//  multiplier issues one product per cycle, N+1 per row, then a drain and a
//  rounding step. A clear item skips the products and zeroes the state. One
//  item is in work at a time; the next is accepted once the result has
//  entered the output register. A stalled output holds the result in place.
//  Reset zeroes the state and clears the output valid.
//
module state_space_plant_step_core #(
    parameter int STATE_COUNT    = ssps_pkg::STATE_COUNT_DEF,
    parameter int COEF_FRAC_BITS = ssps_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input items.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic signed [ssps_pkg::DATA_W-1:0]  i_s_axis_tdata,  // [31:0] sample_in
    input  logic                                i_s_axis_tuser,  // [0] clear_state
    // Result items.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic signed [ssps_pkg::DATA_W-1:0]  o_m_axis_tdata   // [31:0] sample_out
);

    `include "state_space_plant_step_core_macros.svh"

    localparam int DW    = ssps_pkg::DATA_W;
    localparam int CW    = COEF_FRAC_BITS + 2;
    localparam int PW    = CW + DW;
    localparam int ROW_W = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int COL_W = $clog2(STATE_COUNT + 1);
    localparam int ACC_W = PW + COL_W;
    localparam int TD    = ssps_pkg::TABLE_DIM;
    localparam int TIW   = ssps_pkg::TAB_IDX_W;

    localparam logic [ROW_W-1:0]      ROW_LAST = ROW_W'(STATE_COUNT - 1);
    localparam logic [COL_W-1:0]      COL_B    = COL_W'(STATE_COUNT);
    localparam logic signed [ACC_W:0] HALF     = (ACC_W + 1)'(1) <<< (COEF_FRAC_BITS - 1);

    // Sequencer state.
    ssps_pkg::t_pc    r_pc, n_pc;
    ssps_pkg::t_uword w_uw;
    logic             w_jump;

    // Datapath registers.
    logic signed [DW-1:0]    r_state [STATE_COUNT];
    logic signed [DW-1:0]    r_next  [STATE_COUNT];
    logic signed [DW-1:0]    r_u;
    logic                    r_clr;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic signed [PW-1:0]    r_prod;
    logic                    r_prod_vld;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_out_valid;
    logic signed [DW-1:0]    r_out_data;

    // Combinational datapath signals.
    logic signed [CW-1:0]    w_coef_tab [TD][TD+1];
    logic signed [CW-1:0]    w_coef;
    logic signed [DW-1:0]    w_operand;
    logic                    w_col_is_b;
    logic [TIW-1:0]          w_tab_row;
    logic [TIW-1:0]          w_tab_col;
    logic                    w_tab_hit;
    logic signed [ACC_W:0]   w_sum;
    logic signed [ACC_W:0]   w_rnd;
    logic signed [DW-1:0]    w_sat;
    logic                    w_in_accept;

    // Constant coefficient table in Q2.COEF_FRAC_BITS; last column is Bd.
    for (genvar gr = 0; gr < TD; gr++) begin : g_row
        for (genvar gc = 0; gc <= TD; gc++) begin : g_col
            assign w_coef_tab[gr][gc] =
                CW'(ssps_pkg::coef_q(ssps_pkg::tenk_coef(gr, gc), COEF_FRAC_BITS));
        end
    end

    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_pc == ssps_pkg::PC_WAIT);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Microcode fetch and next step.
    always_comb begin
        w_uw = ssps_pkg::uc_rom(r_pc);
        unique case (w_uw.cond)
            ssps_pkg::COND_NONE:     w_jump = 1'b0;
            ssps_pkg::COND_ALWAYS:   w_jump = 1'b1;
            ssps_pkg::COND_NO_START: w_jump = !w_in_accept;
            ssps_pkg::COND_CLEAR:    w_jump = r_clr;
            ssps_pkg::COND_COL_MORE: w_jump = (r_col != COL_B);
            ssps_pkg::COND_ROW_MORE: w_jump = (r_row != ROW_LAST);
            ssps_pkg::COND_OUT_BUSY: w_jump = r_out_valid && !i_m_axis_tready;
            default:                 w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_uw.target : r_pc + ssps_pkg::t_pc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ssps_pkg::PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Coefficient and operand selection for the current row and column.
    always_comb begin
        w_col_is_b = (r_col == COL_B);
        w_tab_row  = '0;
        w_tab_col  = '0;
        w_tab_hit  = 1'b0;
        if (32'(r_row) < TD) begin
            if (w_col_is_b) begin
                w_tab_row = TIW'(r_row);
                w_tab_col = TIW'(TD);
                w_tab_hit = 1'b1;
            end else if (32'(r_col) < TD) begin
                w_tab_row = TIW'(r_row);
                w_tab_col = TIW'(r_col);
                w_tab_hit = 1'b1;
            end
        end
        w_coef    = w_tab_hit ? w_coef_tab[w_tab_row][w_tab_col] : '0;
        w_operand = w_col_is_b ? r_u : r_state[r_col[ROW_W-1:0]];
    end

    // Rounding to Q16.16 and saturation of the accumulated row.
    always_comb begin
        w_sum = (ACC_W + 1)'(r_acc) + HALF;
        w_rnd = w_sum >>> COEF_FRAC_BITS;
        if ((&w_rnd[ACC_W:DW-1]) || !(|w_rnd[ACC_W:DW-1])) begin
            w_sat = w_rnd[DW-1:0];
        end else if (w_rnd[ACC_W]) begin
            w_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    // Control registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < STATE_COUNT; i++) begin
                r_state[i] <= '0;
            end
        end else begin
            r_prod_vld <= (w_uw.op == ssps_pkg::UOP_MAC);
            if (w_uw.op == ssps_pkg::UOP_COMMIT) begin
                r_out_valid <= 1'b1;
                for (int i = 0; i < STATE_COUNT; i++) begin
                    r_state[i] <= r_next[i];
                end
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: item latch, counters, multiplier and accumulator.
    always_ff @(posedge i_clk) begin
        if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        case (w_uw.op)
            ssps_pkg::UOP_WAIT: begin
                if (w_in_accept) begin
                    r_u   <= i_s_axis_tdata;
                    r_clr <= i_s_axis_tuser;
                    r_row <= '0;
                    r_col <= '0;
                    r_acc <= '0;
                end
            end
            ssps_pkg::UOP_MAC: begin
                r_prod <= w_coef * w_operand;
                r_col  <= w_col_is_b ? '0 : r_col + COL_W'(1);
            end
            ssps_pkg::UOP_ROUND: begin
                r_next[r_row] <= w_sat;
                r_row         <= r_row + ROW_W'(1);
                r_acc         <= '0;
            end
            ssps_pkg::UOP_ZERO: begin
                for (int i = 0; i < STATE_COUNT; i++) begin
                    r_next[i] <= '0;
                end
            end
            ssps_pkg::UOP_COMMIT: begin
                r_out_data <= r_next[STATE_COUNT-1];
            end
            default: begin
            end
        endcase
    end

    // The result never overwrites one still waiting at the output.
    `SSPS_ASSERT_NOW(a_commit_free, i_clk, i_rst_n, (w_uw.op == ssps_pkg::UOP_COMMIT), !r_out_valid)
    // All products of a row are summed before it is rounded.
    `SSPS_ASSERT_NOW(a_round_settled, i_clk, i_rst_n, (w_uw.op == ssps_pkg::UOP_ROUND), !r_prod_vld)
    // An accepted item always moves the sequencer on to decoding.
    `SSPS_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, w_in_accept, (r_pc == ssps_pkg::PC_DECODE))

endmodule
